// ===== rtl/kxkconv_pkg.sv =====
// shared constants, types and helper functions of the kxk convolution block
`default_nettype none

package kxkconv_pkg;

  localparam int MAX_KERNEL = 7;
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int LINES = (MAX_KERNEL > 1) ? MAX_KERNEL - 1 : 1;
  localparam int NCOEF = MAX_KERNEL * MAX_KERNEL;

  localparam int PIX_W    = 16;
  localparam int COEF_W   = 16;
  localparam int PROD_W   = PIX_W + COEF_W;
  localparam int ROWSUM_W = PROD_W + $clog2(MAX_KERNEL + 1);
  localparam int SUM_W    = 48;
  localparam int LINE_W   = PIX_W * LINES;

  localparam int DIM_W  = 11;
  localparam int K_W    = 3;
  localparam int CIDX_W = 6;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam int FIFO_AW    = 3;
  localparam int FIFO_DEPTH = 1 << FIFO_AW;

  localparam int WIDTH_RESET  = MAX_WIDTH;
  localparam int HEIGHT_RESET = MAX_HEIGHT;
  localparam int KERNEL_RESET = 3;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_SIZE  = 2'd2;

  localparam logic KIND_COEF  = 1'b0;
  localparam logic KIND_PIXEL = 1'b1;

  typedef logic signed [PIX_W-1:0]    pix_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [ROWSUM_W-1:0] rowsum_t;
  typedef logic signed [SUM_W-1:0]    sum_t;

  typedef pix_t  [LINES-1:0]      line_t;
  typedef pix_t  [MAX_KERNEL-1:0] pix_row_t;
  typedef pix_row_t [MAX_KERNEL-1:0] window_t;
  typedef coef_t [MAX_KERNEL-1:0] coef_row_t;
  typedef coef_row_t [MAX_KERNEL-1:0] lane_coef_t;
  typedef prod_t [MAX_KERNEL-1:0] prod_row_t;

  typedef struct packed {
    logic             emit;
    logic [ROW_W-1:0] out_row;
    logic [COL_W-1:0] out_col;
    logic             last;
  } meta_t;

  typedef struct packed {
    sum_t             sum;
    logic [ROW_W-1:0] out_row;
    logic [COL_W-1:0] out_col;
    logic             frame_end;
  } result_t;

  // newest row enters at slot 0, oldest row drops out
  function automatic line_t line_shift(line_t word, pix_t pix);
    line_t res;
    res = word;
    for (int j = LINES - 1; j > 0; j--) begin
      res[j] = word[j-1];
    end
    res[0] = pix;
    return res;
  endfunction

  function automatic prod_t mul_pc(pix_t a, coef_t b);
    prod_t ea;
    prod_t eb;
    ea = prod_t'(a);
    eb = prod_t'(b);
    return ea * eb;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/kxkconv_if.sv =====
// valid/ready channel interfaces of the kxk convolution block
`default_nettype none

interface kxkconv_in_if;
  logic                              valid;
  logic                              ready;
  logic                              kind;
  logic [kxkconv_pkg::CIDX_W-1:0]    coef_index;
  logic signed [kxkconv_pkg::COEF_W-1:0] coef_value;
  logic signed [kxkconv_pkg::PIX_W-1:0]  pixel;

  modport source(output valid, kind, coef_index, coef_value, pixel, input ready);
  modport sink(input valid, kind, coef_index, coef_value, pixel, output ready);
endinterface

interface kxkconv_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [kxkconv_pkg::SUM_W-1:0]  sum;
  logic [kxkconv_pkg::ROW_W-1:0]         out_row;
  logic [kxkconv_pkg::COL_W-1:0]         out_col;
  logic                                  frame_end;

  modport source(output valid, sum, out_row, out_col, frame_end, input ready);
  modport sink(input valid, sum, out_row, out_col, frame_end, output ready);
endinterface

interface kxkconv_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [kxkconv_pkg::CFG_IDX_W-1:0]   reg_index;
  logic [kxkconv_pkg::CFG_DATA_W-1:0]  data;

  modport source(output valid, reg_index, data, input ready);
  modport sink(input valid, reg_index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/kxkconv_ram.sv =====
// generic simple dual-port ram, registered read-first output
`default_nettype none

module kxkconv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/kxkconv_line.sv =====
// line memory read-modify-write per column and the kxk pixel window
`default_nettype none

module kxkconv_line (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          acc,
  input  logic [kxkconv_pkg::COL_W-1:0] col,
  input  kxkconv_pkg::pix_t             pixel,
  output kxkconv_pkg::window_t          window
);

  logic                          s1_valid;
  logic [kxkconv_pkg::COL_W-1:0] s1_col;
  kxkconv_pkg::pix_t             s1_pix;
  logic                          fwd_hit;
  kxkconv_pkg::line_t            fwd_data;
  logic [kxkconv_pkg::LINE_W-1:0] rd_data;
  kxkconv_pkg::line_t            col_word;
  kxkconv_pkg::line_t            wr_word;

  kxkconv_ram #(
    .WIDTH (kxkconv_pkg::LINE_W),
    .DEPTH (kxkconv_pkg::MAX_WIDTH)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (s1_valid),
    .wr_addr (s1_col),
    .wr_data (wr_word),
    .rd_en   (acc),
    .rd_addr (col),
    .rd_data (rd_data)
  );

  // same column read while it is being written back
  always_comb begin
    col_word = fwd_hit ? fwd_data : kxkconv_pkg::line_t'(rd_data);
    wr_word  = kxkconv_pkg::line_shift(col_word, s1_pix);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fwd_hit  <= 1'b0;
    end else begin
      s1_valid <= acc;
      fwd_hit  <= acc && s1_valid && (s1_col == col);
    end
  end

  always_ff @(posedge clk) begin
    s1_col   <= col;
    s1_pix   <= pixel;
    fwd_data <= wr_word;
  end

  // newest column at the right, current row at the bottom
  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
    end else if (s1_valid) begin
      for (int r = 0; r < kxkconv_pkg::MAX_KERNEL; r++) begin
        for (int c = 0; c < kxkconv_pkg::MAX_KERNEL - 1; c++) begin
          window[r][c] <= window[r][c+1];
        end
      end
      for (int r = 0; r < kxkconv_pkg::MAX_KERNEL - 1; r++) begin
        window[r][kxkconv_pkg::MAX_KERNEL-1] <= col_word[kxkconv_pkg::MAX_KERNEL-2-r];
      end
      window[kxkconv_pkg::MAX_KERNEL-1][kxkconv_pkg::MAX_KERNEL-1] <= s1_pix;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/kxkconv_mac.sv =====
// coefficient store, parallel multipliers and registered adder tree
`default_nettype none

module kxkconv_mac (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           coef_we,
  input  logic [kxkconv_pkg::CIDX_W-1:0] coef_idx,
  input  kxkconv_pkg::coef_t             coef_val,
  input  logic [kxkconv_pkg::K_W-1:0]    ksize,
  input  kxkconv_pkg::window_t           window,
  input  kxkconv_pkg::meta_t             in_meta,
  output logic                           res_valid,
  output kxkconv_pkg::result_t           res
);

  kxkconv_pkg::coef_t      coef [kxkconv_pkg::NCOEF];
  kxkconv_pkg::lane_coef_t lane;
  kxkconv_pkg::lane_coef_t lane_next;
  logic [kxkconv_pkg::MAX_KERNEL-1:0][kxkconv_pkg::MAX_KERNEL-1:0] lane_en;
  logic [kxkconv_pkg::MAX_KERNEL-1:0][kxkconv_pkg::MAX_KERNEL-1:0] lane_en_next;
  kxkconv_pkg::prod_row_t  [kxkconv_pkg::MAX_KERNEL-1:0] prod;
  kxkconv_pkg::rowsum_t    [kxkconv_pkg::MAX_KERNEL-1:0] rowsum;
  kxkconv_pkg::meta_t      s3_meta;
  kxkconv_pkg::meta_t      s4_meta;
  kxkconv_pkg::sum_t       total;

  function automatic kxkconv_pkg::rowsum_t row_add(kxkconv_pkg::prod_row_t pr);
    kxkconv_pkg::rowsum_t acc;
    acc = '0;
    for (int c = 0; c < kxkconv_pkg::MAX_KERNEL; c++) begin
      acc = acc + kxkconv_pkg::ROWSUM_W'($signed(pr[c]));
    end
    return acc;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < kxkconv_pkg::NCOEF; i++) begin
        coef[i] <= '0;
      end
    end else if (coef_we && (coef_idx < kxkconv_pkg::CIDX_W'(kxkconv_pkg::NCOEF))) begin
      coef[coef_idx] <= coef_val;
    end
  end

  // kernel sits in the bottom-right corner of the window
  always_comb begin
    lane_next    = '0;
    lane_en_next = '0;
    for (int kk = 1; kk <= kxkconv_pkg::MAX_KERNEL; kk++) begin
      if (ksize == kxkconv_pkg::K_W'(kk)) begin
        for (int r = 0; r < kxkconv_pkg::MAX_KERNEL; r++) begin
          for (int c = 0; c < kxkconv_pkg::MAX_KERNEL; c++) begin
            if ((r >= kxkconv_pkg::MAX_KERNEL - kk) && (c >= kxkconv_pkg::MAX_KERNEL - kk)) begin
              lane_next[r][c] = coef[(r - (kxkconv_pkg::MAX_KERNEL - kk)) * kk
                                     + c - (kxkconv_pkg::MAX_KERNEL - kk)];
              lane_en_next[r][c] = 1'b1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    lane    <= lane_next;
    lane_en <= lane_en_next;
    for (int r = 0; r < kxkconv_pkg::MAX_KERNEL; r++) begin
      for (int c = 0; c < kxkconv_pkg::MAX_KERNEL; c++) begin
        prod[r][c] <= lane_en[r][c] ? kxkconv_pkg::mul_pc(window[r][c], lane[r][c]) : '0;
      end
    end
    for (int r = 0; r < kxkconv_pkg::MAX_KERNEL; r++) begin
      rowsum[r] <= row_add(prod[r]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_meta <= '0;
      s4_meta <= '0;
    end else begin
      s3_meta <= in_meta;
      s4_meta <= s3_meta;
    end
  end

  always_comb begin
    total = '0;
    for (int r = 0; r < kxkconv_pkg::MAX_KERNEL; r++) begin
      total = total + kxkconv_pkg::SUM_W'($signed(rowsum[r]));
    end
  end

  assign res_valid     = s4_meta.emit;
  assign res.sum       = total;
  assign res.out_row   = s4_meta.out_row;
  assign res.out_col   = s4_meta.out_col;
  assign res.frame_end = s4_meta.last;

endmodule

`default_nettype wire

// ===== rtl/kxkconv_ofifo.sv =====
// result queue between the adder tree and the output channel
`default_nettype none

module kxkconv_ofifo (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  kxkconv_pkg::result_t wr_data,
  input  logic                 rd_en,
  output kxkconv_pkg::result_t rd_data,
  output logic                 not_empty
);

  kxkconv_pkg::result_t             mem [kxkconv_pkg::FIFO_DEPTH];
  logic [kxkconv_pkg::FIFO_AW-1:0]  wr_ptr;
  logic [kxkconv_pkg::FIFO_AW-1:0]  rd_ptr;
  logic [kxkconv_pkg::FIFO_AW:0]    count;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + kxkconv_pkg::FIFO_AW'(1);
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + kxkconv_pkg::FIFO_AW'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + (kxkconv_pkg::FIFO_AW + 1)'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - (kxkconv_pkg::FIFO_AW + 1)'(1);
      end
    end
  end

  assign rd_data   = mem[rd_ptr];
  assign not_empty = (count != '0);

endmodule

`default_nettype wire

// ===== rtl/kxk_image_convolution.sv =====
// top level of the kxk valid-region image convolution
//
// channel  dir  word                                   handshake
// stream   in   kind, coef_index, coef_value, pixel    valid/ready
// result   out  sum, out_row, out_col, frame_end       valid/ready
// cfg      in   reg_index, data                        valid/ready, ready always high
//
// one word per cycle while stream ready is high; results are registered up to the queue
// the line memory is read and written once per pixel at the pixel's column, one port each
// stream ready drops while 8 results are pending, which the result queue absorbs
// reset clears counters, registers, coefficients and the queue; the line memory is not swept
`default_nettype none

module kxk_image_convolution (
  input  logic          clk,
  input  logic          rst,
  kxkconv_in_if.sink    stream,
  kxkconv_out_if.source result,
  kxkconv_cfg_if.sink   cfg
);

  logic [kxkconv_pkg::DIM_W-1:0] img_w;
  logic [kxkconv_pkg::DIM_W-1:0] img_h;
  logic [kxkconv_pkg::K_W-1:0]   ksize;
  logic [kxkconv_pkg::COL_W-1:0] col_count;
  logic [kxkconv_pkg::ROW_W-1:0] row_count;
  logic [kxkconv_pkg::COL_W-1:0] col_count_next;
  logic [kxkconv_pkg::ROW_W-1:0] row_count_next;
  logic [kxkconv_pkg::FIFO_AW:0] pend;
  logic [kxkconv_pkg::FIFO_AW:0] pend_next;

  logic                          in_acc;
  logic                          pix_acc;
  logic                          coef_we;
  logic                          cfg_we;
  logic                          cfg_known;
  logic                          out_acc;
  logic [kxkconv_pkg::K_W-1:0]   k1;
  logic                          col_wrap;
  logic                          row_wrap;
  kxkconv_pkg::meta_t            meta_now;
  kxkconv_pkg::meta_t            s1_meta;
  kxkconv_pkg::meta_t            s2_meta;
  kxkconv_pkg::window_t          window;
  logic                          mac_valid;
  kxkconv_pkg::result_t          mac_res;
  kxkconv_pkg::result_t          fifo_out;
  logic                          fifo_ne;

  assign in_acc  = stream.valid && stream.ready;
  assign pix_acc = in_acc && (stream.kind == kxkconv_pkg::KIND_PIXEL);
  assign coef_we = in_acc && (stream.kind == kxkconv_pkg::KIND_COEF);
  assign cfg_we  = cfg.valid && cfg.ready;
  assign out_acc = result.valid && result.ready;

  assign cfg.ready    = 1'b1;
  assign stream.ready = (pend < (kxkconv_pkg::FIFO_AW + 1)'(kxkconv_pkg::FIFO_DEPTH));

  assign cfg_known = (cfg.reg_index == kxkconv_pkg::REG_IMAGE_WIDTH)
                  || (cfg.reg_index == kxkconv_pkg::REG_IMAGE_HEIGHT)
                  || (cfg.reg_index == kxkconv_pkg::REG_KERNEL_SIZE);

  always_ff @(posedge clk) begin
    if (rst) begin
      img_w <= kxkconv_pkg::DIM_W'(kxkconv_pkg::WIDTH_RESET);
      img_h <= kxkconv_pkg::DIM_W'(kxkconv_pkg::HEIGHT_RESET);
      ksize <= kxkconv_pkg::K_W'(kxkconv_pkg::KERNEL_RESET);
    end else if (cfg_we) begin
      case (cfg.reg_index)
        kxkconv_pkg::REG_IMAGE_WIDTH: begin
          if (cfg.data == '0) begin
            img_w <= kxkconv_pkg::DIM_W'(1);
          end else if (cfg.data > kxkconv_pkg::DIM_W'(kxkconv_pkg::MAX_WIDTH)) begin
            img_w <= kxkconv_pkg::DIM_W'(kxkconv_pkg::MAX_WIDTH);
          end else begin
            img_w <= cfg.data;
          end
        end
        kxkconv_pkg::REG_IMAGE_HEIGHT: begin
          if (cfg.data == '0) begin
            img_h <= kxkconv_pkg::DIM_W'(1);
          end else if (cfg.data > kxkconv_pkg::DIM_W'(kxkconv_pkg::MAX_HEIGHT)) begin
            img_h <= kxkconv_pkg::DIM_W'(kxkconv_pkg::MAX_HEIGHT);
          end else begin
            img_h <= cfg.data;
          end
        end
        kxkconv_pkg::REG_KERNEL_SIZE: begin
          if (cfg.data[kxkconv_pkg::K_W-1:0] == '0) begin
            ksize <= kxkconv_pkg::K_W'(1);
          end else if (cfg.data[kxkconv_pkg::K_W-1:0] > kxkconv_pkg::K_W'(kxkconv_pkg::MAX_KERNEL)) begin
            ksize <= kxkconv_pkg::K_W'(kxkconv_pkg::MAX_KERNEL);
          end else begin
            ksize <= cfg.data[kxkconv_pkg::K_W-1:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  // raster position and window bookkeeping of the incoming pixel
  always_comb begin
    k1       = ksize - kxkconv_pkg::K_W'(1);
    col_wrap = (kxkconv_pkg::DIM_W'(col_count) + kxkconv_pkg::DIM_W'(1)) >= img_w;
    row_wrap = (kxkconv_pkg::DIM_W'(row_count) + kxkconv_pkg::DIM_W'(1)) >= img_h;
    col_count_next = col_wrap ? '0 : col_count + kxkconv_pkg::COL_W'(1);
    if (col_wrap) begin
      row_count_next = row_wrap ? '0 : row_count + kxkconv_pkg::ROW_W'(1);
    end else begin
      row_count_next = row_count;
    end
    meta_now.emit    = pix_acc && (row_count >= kxkconv_pkg::ROW_W'(k1))
                                && (col_count >= kxkconv_pkg::COL_W'(k1));
    meta_now.out_row = row_count - kxkconv_pkg::ROW_W'(k1);
    meta_now.out_col = col_count - kxkconv_pkg::COL_W'(k1);
    meta_now.last    = ((kxkconv_pkg::DIM_W'(row_count) + kxkconv_pkg::DIM_W'(1)) == img_h)
                    && ((kxkconv_pkg::DIM_W'(col_count) + kxkconv_pkg::DIM_W'(1)) == img_w);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (cfg_we && cfg_known) begin
      col_count <= '0;
      row_count <= '0;
    end else if (pix_acc) begin
      col_count <= col_count_next;
      row_count <= row_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_meta <= '0;
      s2_meta <= '0;
    end else begin
      s1_meta <= meta_now;
      s2_meta <= s1_meta;
    end
  end

  // results accepted but not yet taken
  always_comb begin
    pend_next = pend;
    if (meta_now.emit && !out_acc) begin
      pend_next = pend + (kxkconv_pkg::FIFO_AW + 1)'(1);
    end else if (out_acc && !meta_now.emit) begin
      pend_next = pend - (kxkconv_pkg::FIFO_AW + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else begin
      pend <= pend_next;
    end
  end

  kxkconv_line u_line (
    .clk    (clk),
    .rst    (rst),
    .acc    (pix_acc),
    .col    (col_count),
    .pixel  (stream.pixel),
    .window (window)
  );

  kxkconv_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .coef_we   (coef_we),
    .coef_idx  (stream.coef_index),
    .coef_val  (stream.coef_value),
    .ksize     (ksize),
    .window    (window),
    .in_meta   (s2_meta),
    .res_valid (mac_valid),
    .res       (mac_res)
  );

  kxkconv_ofifo u_ofifo (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (mac_valid),
    .wr_data   (mac_res),
    .rd_en     (out_acc),
    .rd_data   (fifo_out),
    .not_empty (fifo_ne)
  );

  assign result.valid     = fifo_ne;
  assign result.sum       = fifo_out.sum;
  assign result.out_row   = fifo_out.out_row;
  assign result.out_col   = fifo_out.out_col;
  assign result.frame_end = fifo_out.frame_end;

`ifndef ASSERT_OFF
  a_pend_bound: assert property (@(posedge clk) disable iff (rst)
    pend <= (kxkconv_pkg::FIFO_AW + 1)'(kxkconv_pkg::FIFO_DEPTH))
    else $error("pending result count above queue depth");

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    kxkconv_pkg::DIM_W'(col_count) < img_w)
    else $error("column counter outside image width");

  a_row_range: assert property (@(posedge clk) disable iff (rst)
    kxkconv_pkg::DIM_W'(row_count) < img_h)
    else $error("row counter outside image height");

  a_coef_silent: assert property (@(posedge clk) disable iff (rst)
    coef_we |=> !s1_meta.emit)
    else $error("coefficient word produced a result");

  a_fifo_credit: assert property (@(posedge clk) disable iff (rst)
    mac_valid |-> (pend != '0))
    else $error("result written without a pending credit");
`endif

endmodule

`default_nettype wire
